// ----- rtl/edc_pkg.sv -----
// ----------------------------------------------------------------------------
// edc_pkg
// Shared types and constants of the escape byte deframer and command decoder.
// ----------------------------------------------------------------------------
package edc_pkg;

  localparam int NUM_BOARDS   = 4;
  localparam int PAYLOAD_KEPT = 6;
  localparam int QUEUE_DEPTH  = 4;

  localparam int IDX_W  = $clog2(PAYLOAD_KEPT);
  localparam int CNT_W  = $clog2(PAYLOAD_KEPT + 1);
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] ESC_BYTE    = 8'hFF;
  localparam logic [7:0] OPEN_BYTE   = 8'hFE;
  localparam logic [7:0] CLOSE_BYTE  = 8'hFD;
  localparam logic [7:0] CMD_WALL    = 8'd0;
  localparam logic [7:0] CMD_PICTURE = 8'd1;
  localparam logic [7:0] CMD_STATUS  = 8'd10;
  localparam logic [7:0] BOARD_LIMIT = 8'(NUM_BOARDS);
  localparam logic [7:0] BOARD_ID_RESET = 8'd1;

  typedef enum logic [1:0] {
    OP_OPEN,
    OP_PUSH,
    OP_CLOSE
  } edc_op_t;

  typedef struct packed {
    edc_op_t    op;
    logic [7:0] data;
  } edc_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } edc_q_status_t;

  typedef enum logic [2:0] {
    KIND_WALL        = 3'd0,
    KIND_PICTURE     = 3'd1,
    KIND_STATUS      = 3'd2,
    KIND_UNKNOWN     = 3'd3,
    KIND_OTHER_BOARD = 3'd4,
    KIND_BAD_SLOT    = 3'd5,
    KIND_EMPTY       = 3'd6
  } edc_kind_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] target_board;
    logic [7:0] picture_number;
    logic [7:0] wall_north;
    logic [7:0] wall_east;
    logic [7:0] wall_south;
    logic [7:0] wall_west;
  } edc_result_t;

endpackage

// ----- rtl/edc_if.sv -----
// ----------------------------------------------------------------------------
// edc_if
// Valid/ready channels for received bytes and decoded command results.
// ----------------------------------------------------------------------------
interface edc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface edc_result_if;
  logic                 valid;
  logic                 ready;
  edc_pkg::edc_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/edc_front.sv -----
// ----------------------------------------------------------------------------
// edc_front
// Byte classifier: tracks framing and escapes, emits open/push/close words.
// ----------------------------------------------------------------------------
module edc_front (
  input  logic                   clk,
  input  logic                   rst,
  edc_byte_if.sink               rx,
  input  edc_pkg::edc_q_status_t q_status,
  output logic                   push,
  output edc_pkg::edc_cmd_t      push_cmd
);

  logic       in_frame;
  logic       in_frame_next;
  logic [7:0] last_byte;
  logic [7:0] last_byte_next;
  logic       emit;
  logic       take;

  assign rx.ready = !q_status.full;
  assign take     = rx.valid && rx.ready;
  assign push     = take && emit;

  always_comb begin
    in_frame_next  = in_frame;
    last_byte_next = rx.rx_byte;
    emit           = 1'b0;
    push_cmd.op    = edc_pkg::OP_PUSH;
    push_cmd.data  = rx.rx_byte;
    if (!in_frame) begin
      if (last_byte == edc_pkg::ESC_BYTE && rx.rx_byte == edc_pkg::OPEN_BYTE) begin
        in_frame_next = 1'b1;
        emit          = 1'b1;
        push_cmd.op   = edc_pkg::OP_OPEN;
      end
    end else if (rx.rx_byte == edc_pkg::ESC_BYTE) begin
      if (last_byte == edc_pkg::ESC_BYTE) begin
        emit           = 1'b1;
        last_byte_next = 8'h00;
      end
    end else if (last_byte == edc_pkg::ESC_BYTE && rx.rx_byte == edc_pkg::CLOSE_BYTE) begin
      in_frame_next = 1'b0;
      emit          = 1'b1;
      push_cmd.op   = edc_pkg::OP_CLOSE;
    end else begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      last_byte <= edc_pkg::ESC_BYTE;
    end else if (take) begin
      in_frame  <= in_frame_next;
      last_byte <= last_byte_next;
    end
  end

endmodule

// ----- rtl/edc_queue.sv -----
// ----------------------------------------------------------------------------
// edc_queue
// Short word queue between the byte classifier and the frame decoder.
// ----------------------------------------------------------------------------
module edc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  edc_pkg::edc_cmd_t      push_cmd,
  input  logic                   pop,
  output edc_pkg::edc_cmd_t      head,
  output edc_pkg::edc_q_status_t q_status
);

  edc_pkg::edc_cmd_t              mem [edc_pkg::QUEUE_DEPTH];
  logic [edc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [edc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [edc_pkg::QCNT_W-1:0]     count;

  localparam logic [edc_pkg::QPTR_W-1:0] LAST_PTR = edc_pkg::QPTR_W'(edc_pkg::QUEUE_DEPTH - 1);
  localparam logic [edc_pkg::QCNT_W-1:0] FULL_CNT = edc_pkg::QCNT_W'(edc_pkg::QUEUE_DEPTH);

  assign head           = mem[rd_ptr];
  assign q_status.full  = (count == FULL_CNT);
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/edc_back.sv -----
// ----------------------------------------------------------------------------
// edc_back
// Frame decoder: keeps the payload, decodes the command at frame close.
// ----------------------------------------------------------------------------
module edc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  input  edc_pkg::edc_cmd_t      head,
  input  edc_pkg::edc_q_status_t q_status,
  output logic                   pop,
  edc_result_if.source           result
);

  logic [7:0]                own_board_id;
  logic [7:0]                store [edc_pkg::PAYLOAD_KEPT];
  logic [edc_pkg::CNT_W-1:0] count;
  logic                      res_valid;
  edc_pkg::edc_result_t      res;
  edc_pkg::edc_result_t      res_next;
  logic                      slot_free;

  localparam logic [edc_pkg::CNT_W-1:0] KEPT_CNT = edc_pkg::CNT_W'(edc_pkg::PAYLOAD_KEPT);

  assign slot_free      = !res_valid || result.ready;
  assign pop            = !q_status.empty && (head.op != edc_pkg::OP_CLOSE || slot_free);
  assign result.valid   = res_valid;
  assign result.payload = res;

  always_comb begin
    res_next = '0;
    if (count == '0) begin
      res_next.kind = edc_pkg::KIND_EMPTY;
    end else if (store[0] == edc_pkg::CMD_WALL) begin
      res_next.kind = edc_pkg::KIND_WALL;
    end else if (store[0] == edc_pkg::CMD_PICTURE) begin
      res_next.target_board = store[1];
      if (store[1] == own_board_id) begin
        res_next.kind           = edc_pkg::KIND_PICTURE;
        res_next.picture_number = store[2];
      end else begin
        res_next.kind = edc_pkg::KIND_OTHER_BOARD;
      end
    end else if (store[0] == edc_pkg::CMD_STATUS) begin
      res_next.target_board = store[1];
      if (store[1] != 8'd0 && store[1] <= edc_pkg::BOARD_LIMIT) begin
        res_next.kind       = edc_pkg::KIND_STATUS;
        res_next.wall_north = store[2];
        res_next.wall_east  = store[3];
        res_next.wall_south = store[4];
        res_next.wall_west  = store[5];
      end else begin
        res_next.kind = edc_pkg::KIND_BAD_SLOT;
      end
    end else begin
      res_next.kind = edc_pkg::KIND_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_board_id <= edc_pkg::BOARD_ID_RESET;
    end else if (cfg_wr_en) begin
      own_board_id <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < edc_pkg::PAYLOAD_KEPT; i++) begin
        store[i] <= 8'h00;
      end
    end else begin
      if (pop && head.op == edc_pkg::OP_CLOSE) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (pop) begin
        case (head.op)
          edc_pkg::OP_OPEN: begin
            count <= '0;
            for (int i = 0; i < edc_pkg::PAYLOAD_KEPT; i++) begin
              store[i] <= 8'h00;
            end
          end
          edc_pkg::OP_PUSH: begin
            if (count < KEPT_CNT) begin
              store[count[edc_pkg::IDX_W-1:0]] <= head.data;
              count <= count + 1'b1;
            end
          end
          edc_pkg::OP_CLOSE: begin
            count <= '0;
            res   <= res_next;
          end
          default: begin
            count <= count;
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/escape_byte_deframer_command_decode.sv -----
// ----------------------------------------------------------------------------
// escape_byte_deframer_command_decode
// Escape-byte deframer with board command decode, one result per frame.
// Throughput: one byte per cycle while the word queue is not full.
// A closing word passes through the word queue, then the result register.
// The four-word queue lets the classifier run while a result waits.
// Reset: synchronous, clears framing, queue, payload store, board id to 1.
// ----------------------------------------------------------------------------
module escape_byte_deframer_command_decode (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  edc_byte_if.sink     rx,
  edc_result_if.source result
);

  edc_pkg::edc_q_status_t q_status;
  edc_pkg::edc_cmd_t      push_cmd;
  edc_pkg::edc_cmd_t      head;
  logic                   push;
  logic                   pop;

  edc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  edc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  edc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .result      (result)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !push)
    else $error("word pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> !pop)
    else $error("word popped from empty queue");

  a_close_gives_result: assert property (@(posedge clk) disable iff (rst)
    (pop && head.op == edc_pkg::OP_CLOSE) |=> result.valid)
    else $error("frame close produced no result");

endmodule

// ----- verif/edc_command_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edc_command_checker
// Watches the byte and result channels of the deframer, tracks framing,
// payload and board id on its own, and compares every decoded result with
// the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module edc_command_checker
  import edc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  edc_byte_if        rx,
  edc_result_if      result,
  output int         failures,
  output int         pending,
  output int         results_seen,
  output logic [6:0] kinds_seen
);

  logic [7:0]  board_id;
  logic        framing;
  logic [7:0]  prev_byte;
  int          kept_count;
  logic [7:0]  kept [PAYLOAD_KEPT];
  edc_result_t decoded_q [$];

  function void keep_byte(input logic [7:0] v);
    if (kept_count < PAYLOAD_KEPT) begin
      kept[kept_count] = v;
      kept_count++;
    end
  endfunction

  task check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      failures++;
      $display("%0t checker: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : watch
    edc_result_t want;
    edc_result_t got;
    logic [7:0]  b;
    if (rst) begin
      board_id     = BOARD_ID_RESET;
      framing      = 1'b0;
      prev_byte    = ESC_BYTE;
      kept_count   = 0;
      foreach (kept[i]) kept[i] = 8'h00;
      decoded_q.delete();
      failures     = 0;
      results_seen = 0;
      kinds_seen   = '0;
    end else begin
      if (cfg_wr_en) board_id = cfg_wr_data;

      if (result.valid && result.ready) begin
        got = result.payload;
        if (decoded_q.size() == 0) begin
          failures++;
          $display("%0t checker: result with nothing expected, got kind %0d", $time, got.kind);
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", 8'(want.kind), 8'(got.kind));
          check_field("target_board", want.target_board, got.target_board);
          check_field("picture_number", want.picture_number, got.picture_number);
          check_field("wall_north", want.wall_north, got.wall_north);
          check_field("wall_east", want.wall_east, got.wall_east);
          check_field("wall_south", want.wall_south, got.wall_south);
          check_field("wall_west", want.wall_west, got.wall_west);
          results_seen++;
          kinds_seen[want.kind] = 1'b1;
        end
      end

      if (rx.valid && rx.ready) begin
        b = rx.rx_byte;
        if (!framing) begin
          if (prev_byte == ESC_BYTE && b == OPEN_BYTE) begin
            framing    = 1'b1;
            kept_count = 0;
            foreach (kept[i]) kept[i] = 8'h00;
          end
          prev_byte = b;
        end else if (b == ESC_BYTE) begin
          if (prev_byte == ESC_BYTE) begin
            keep_byte(ESC_BYTE);
            prev_byte = 8'h00;
          end else begin
            prev_byte = ESC_BYTE;
          end
        end else if (prev_byte == ESC_BYTE && b == CLOSE_BYTE) begin
          want = '0;
          if (kept_count == 0) begin
            want.kind = KIND_EMPTY;
          end else if (kept[0] == CMD_WALL) begin
            want.kind = KIND_WALL;
          end else if (kept[0] == CMD_PICTURE) begin
            want.target_board = kept[1];
            if (kept[1] == board_id) begin
              want.kind           = KIND_PICTURE;
              want.picture_number = kept[2];
            end else begin
              want.kind = KIND_OTHER_BOARD;
            end
          end else if (kept[0] == CMD_STATUS) begin
            want.target_board = kept[1];
            if (kept[1] >= 8'd1 && kept[1] <= BOARD_LIMIT) begin
              want.kind       = KIND_STATUS;
              want.wall_north = kept[2];
              want.wall_east  = kept[3];
              want.wall_south = kept[4];
              want.wall_west  = kept[5];
            end else begin
              want.kind = KIND_BAD_SLOT;
            end
          end else begin
            want.kind = KIND_UNKNOWN;
          end
          decoded_q.push_back(want);
          framing    = 1'b0;
          kept_count = 0;
          prev_byte  = b;
        end else begin
          keep_byte(b);
          prev_byte = b;
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

// ----- verif/escape_byte_deframer_command_decode_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escape_byte_deframer_command_decode_tb
// Feeds escaped byte frames into the deframer: a directed opening, then
// phases of random frames and line noise under several board ids, with
// random gaps on both channels. The checker beside the block predicts and
// compares; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module escape_byte_deframer_command_decode_tb;
  import edc_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  edc_byte_if   rx_if ();
  edc_result_if res_if ();

  int         failures;
  int         pending;
  int         results_seen;
  logic [6:0] kinds_seen;

  logic [7:0] own_id;
  bit         idle_on;
  int         bytes_sent;
  int         id_settings;

  // empty frame; picture for this board; status with escaped FF board,
  // FE inside a frame, dropped lone FF and an overlong payload
  localparam logic [7:0] INTRO [25] = '{
    ESC_BYTE, OPEN_BYTE, ESC_BYTE, CLOSE_BYTE,
    ESC_BYTE, OPEN_BYTE, CMD_PICTURE, BOARD_ID_RESET, 8'h07, ESC_BYTE, CLOSE_BYTE,
    ESC_BYTE, OPEN_BYTE, CMD_STATUS, ESC_BYTE, ESC_BYTE, OPEN_BYTE, ESC_BYTE,
    8'h05, 8'h06, 8'h07, 8'h08, 8'h09, ESC_BYTE, CLOSE_BYTE
  };

  escape_byte_deframer_command_decode dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx_if),
    .result      (res_if)
  );

  edc_command_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .rx           (rx_if),
    .result       (res_if),
    .failures     (failures),
    .pending      (pending),
    .results_seen (results_seen),
    .kinds_seen   (kinds_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #500000;
    $display("tb: failure");
    $finish;
  end

  function logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return ESC_BYTE;
      1: return OPEN_BYTE;
      2: return CLOSE_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  task send_word(input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // close any open frame, drop valid and drain
  task settle();
    send_word(8'h00);
    send_word(ESC_BYTE);
    send_word(CLOSE_BYTE);
    rx_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task set_board_id(input logic [7:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    own_id = v;
    id_settings++;
    @(negedge clk);
  endtask

  task run_random_phase(input int n);
    int         start;
    int         roll;
    int         len;
    int         i;
    logic [7:0] cmd;
    logic [7:0] board;
    logic [7:0] v;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        case ($urandom_range(0, 5))
          0:       cmd = CMD_WALL;
          1, 2:    cmd = CMD_PICTURE;
          3, 4:    cmd = CMD_STATUS;
          default: cmd = 8'($urandom);
        endcase
        if (cmd == CMD_PICTURE)
          board = $urandom_range(0, 1) ? own_id : 8'($urandom);
        else if (cmd == CMD_STATUS)
          board = $urandom_range(0, 3) ? 8'($urandom_range(1, NUM_BOARDS)) :
                  ($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(NUM_BOARDS + 1, 255)));
        else
          board = 8'($urandom);
        len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : $urandom_range(3, 6);
        send_word(ESC_BYTE);
        send_word(OPEN_BYTE);
        for (i = 0; i < len; i++) begin
          v = (i == 0) ? cmd : (i == 1) ? board : pick_byte();
          if (v == ESC_BYTE) begin
            send_word(ESC_BYTE);
            send_word(ESC_BYTE);
          end else begin
            if ($urandom_range(0, 9) == 0 && v != CLOSE_BYTE) send_word(ESC_BYTE);
            send_word(v);
          end
        end
        send_word(ESC_BYTE);
        send_word(CLOSE_BYTE);
      end else begin
        if (roll < 93) begin
          send_word(ESC_BYTE);
          send_word(OPEN_BYTE);
        end
        repeat ($urandom_range(1, 6)) send_word(pick_byte());
      end
    end
  endtask

  initial begin
    res_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin : result_stall
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    own_id        = BOARD_ID_RESET;
    idle_on       = 1'b1;
    bytes_sent    = 0;
    id_settings   = 1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (INTRO[i]) send_word(INTRO[i]);

    set_board_id(8'hFF);
    run_random_phase(380);
    set_board_id(BOARD_ID_RESET);
    run_random_phase(380);
    set_board_id(8'($urandom_range(2, 254)));
    run_random_phase(380);
    set_board_id(BOARD_LIMIT);
    idle_on = 1'b0;
    run_random_phase(380);
    set_board_id(8'($urandom_range(1, 255)));
    idle_on = 1'b1;
    run_random_phase(380);
    settle();

    $display("tb: sent %0d bytes under %0d board id settings", bytes_sent, id_settings);
    $display("tb: checked %0d decoded frames, kinds seen %b", results_seen, kinds_seen);
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
